/* src/mbsr_pkg.sv */
// shared types and constants for the midi byte stream receiver
// no dependencies; imported by every module of the block
package mbsr_pkg;

  // payload widths of the stream channels
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // default depth of the result queue (at least two)
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PORT_CHANGE_EN = 1'b0,
    CFG_BASE_PORT      = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_FIRST,
    PH_SECOND,
    PH_ONE,
    PH_SYSEX,
    PH_PORT
  } phase_e;

  typedef enum logic [4:0] {
    K_KEY_OFF,
    K_KEY_ON,
    K_KEY_PRESSURE,
    K_CONTROL,
    K_PROGRAM,
    K_CHAN_PRESSURE,
    K_PITCH,
    K_SONG_POS,
    K_SONG_SEL,
    K_QFRAME,
    K_TUNE,
    K_CLOCK,
    K_START,
    K_CONTINUE,
    K_STOP,
    K_SENSING,
    K_RESET,
    K_SYSEX_BYTE,
    K_SYSEX_END
  } kind_e;

  // one decoded message; packs to the output tdata layout plus last
  typedef struct packed {
    logic [7:0]  port_number;
    logic [31:0] stamp;
    logic [6:0]  second_value;
    logic [6:0]  first_value;
    logic [3:0]  channel;
    kind_e       kind;
    logic        last;
  } result_t;

  // up to two results handed together from the parser to the queue
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res1;
    result_t    res0;
  } push_t;

endpackage

/* src/midi_byte_stream_receiver.sv */
// top level of the midi byte stream receiver
// depends on mbsr_pkg, mbsr_parser and mbsr_out_fifo
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata = rx_byte, now
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata = result fields, tlast = last
//  cfg       in   cfg_we_i (no back-pressure)   cfg_idx_i, cfg_wdata_i
//
// one received byte is taken per cycle while the result queue has room; each
// request is held in the input register, is decoded there and its results land
// in the result queue; the queue drains one result per cycle while m_axis_tready
// is high, so a byte with two results (sysex end followed by tune request) takes
// two output transfers; results reach m_axis via the input register and the queue
// reset clears parse state, configuration and queue at once; no clearing pass
// a stalled output fills the queue, then back-pressure reaches s_axis_tready
module midi_byte_stream_receiver import mbsr_pkg::*; #(
  parameter int unsigned OutDepth = OUT_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // fields from bit 0: rx_byte[7:0], now[39:8]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: kind[4:0], channel[8:5], first_value[15:9],
  // second_value[22:16], stamp[54:23], port_number[62:55], zero[63]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  push_t   push;
  logic    room;
  result_t head;

  // parser: input register, running status state, decode of one byte
  mbsr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .now_i       (s_axis_tdata[39:8]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .room_i      (room),
    .push_o      (push)
  );

  // result queue; room for two means a decoded byte never loses a result
  mbsr_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (head)
  );

  // pack result fields, lowest first, pad to whole bytes
  assign m_axis_tdata = {1'b0, head.port_number, head.stamp, head.second_value,
                         head.first_value, head.channel, head.kind};
  assign m_axis_tlast = head.last;

endmodule

/* src/mbsr_parser.sv */
// input register, running status parser state and result decode
// depends on mbsr_pkg
module mbsr_parser import mbsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  input  logic [31:0]           now_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  room_i,
  output push_t                 push_o
);

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_QFRAME   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_PORT     = 8'hF5;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_SENSING  = 8'hFE;
  localparam logic [7:0] ST_RESET    = 8'hFF;

  logic        stage_v_q;
  logic [7:0]  byte_q;
  logic [31:0] now_q;
  logic        fire;

  logic        pc_en_q;
  logic [7:0]  base_port_q;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [3:0]  chan_q, chan_d;
  logic [6:0]  held_q, held_d;
  logic [31:0] time_q, time_d;
  logic [7:0]  port_q, port_d;

  result_t     res [2];
  logic [1:0]  n;
  logic        do_status;

  function automatic result_t mk(kind_e k, logic [3:0] ch, logic [6:0] v1, logic [6:0] v2,
                                 logic [31:0] st, logic [7:0] pn);
    result_t r;
    r.kind         = k;
    r.channel      = ch;
    r.first_value  = v1;
    r.second_value = v2;
    r.stamp        = st;
    r.port_number  = pn;
    r.last         = 1'b0;
    return r;
  endfunction

  assign fire       = stage_v_q & room_i;
  assign in_ready_o = ~stage_v_q | room_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      stage_v_q <= 1'b1;
    end else if (fire) begin
      stage_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      now_q  <= now_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_en_q     <= 1'b0;
      base_port_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PORT_CHANGE_EN: pc_en_q     <= cfg_wdata_i[0];
        CFG_BASE_PORT:      base_port_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      kind_q  <= K_KEY_OFF;
      chan_q  <= '0;
      held_q  <= '0;
      time_q  <= '0;
      port_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      held_q  <= held_d;
      time_q  <= time_d;
      port_q  <= port_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    chan_d    = chan_q;
    held_d    = held_q;
    time_d    = time_q;
    port_d    = port_q;
    res[0]    = mk(K_KEY_OFF, '0, '0, '0, '0, '0);
    res[1]    = mk(K_KEY_OFF, '0, '0, '0, '0, '0);
    n         = 2'd0;
    do_status = 1'b0;

    if (phase_q == PH_SYSEX) begin
      if (!byte_q[7]) begin
        res[0] = mk(K_SYSEX_BYTE, '0, byte_q[6:0], '0, time_q, port_q);
        n      = 2'd1;
      end else if (byte_q >= ST_CLOCK) begin
        // real-time bytes pass through without closing the sysex
        do_status = 1'b1;
      end else begin
        res[0]  = mk(K_SYSEX_END, '0, '0, '0, time_q, port_q);
        n       = 2'd1;
        phase_d = PH_WAIT;
        if (byte_q != ST_EOX) begin
          do_status = 1'b1;
        end
      end
    end else if (byte_q[7]) begin
      do_status = 1'b1;
    end else begin
      case (phase_q)
        PH_FIRST: begin
          time_d  = now_q;
          held_d  = byte_q[6:0];
          phase_d = PH_SECOND;
        end
        PH_SECOND: begin
          res[0]  = mk(kind_q, chan_q, held_q, byte_q[6:0], time_q, port_q);
          n       = 2'd1;
          phase_d = PH_FIRST;
        end
        PH_ONE: begin
          if (kind_q == K_QFRAME) begin
            res[0] = mk(K_QFRAME, '0, {4'b0000, byte_q[6:4]}, {3'b000, byte_q[3:0]},
                        now_q, port_q);
          end else begin
            res[0] = mk(kind_q, chan_q, byte_q[6:0], '0, now_q, port_q);
          end
          n = 2'd1;
        end
        PH_PORT: begin
          port_d = (byte_q == 8'h00) ? 8'h00 : base_port_q + byte_q;
        end
        default: ;
      endcase
    end

    if (do_status) begin
      unique case (byte_q) inside
        [8'h80:8'hEF]: begin
          kind_d  = kind_e'({2'b00, byte_q[6:4]});
          chan_d  = byte_q[3:0];
          held_d  = '0;
          phase_d = (kind_d == K_PROGRAM || kind_d == K_CHAN_PRESSURE) ? PH_ONE : PH_FIRST;
        end
        ST_SYSEX: begin
          phase_d = PH_SYSEX;
          time_d  = now_q;
        end
        ST_QFRAME: begin
          kind_d  = K_QFRAME;
          chan_d  = '0;
          held_d  = '0;
          phase_d = PH_ONE;
        end
        ST_SONG_POS: begin
          kind_d  = K_SONG_POS;
          chan_d  = '0;
          held_d  = '0;
          phase_d = PH_FIRST;
        end
        ST_SONG_SEL: begin
          kind_d  = K_SONG_SEL;
          chan_d  = '0;
          held_d  = '0;
          phase_d = PH_ONE;
        end
        ST_PORT: begin
          if (pc_en_q) begin
            phase_d = PH_PORT;
          end
        end
        ST_TUNE: begin
          res[n[0]] = mk(K_TUNE, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_CLOCK: begin
          res[n[0]] = mk(K_CLOCK, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_START: begin
          res[n[0]] = mk(K_START, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_CONTINUE: begin
          res[n[0]] = mk(K_CONTINUE, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_STOP: begin
          res[n[0]] = mk(K_STOP, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_SENSING: begin
          res[n[0]] = mk(K_SENSING, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        ST_RESET: begin
          res[n[0]] = mk(K_RESET, '0, '0, '0, now_q, port_q);
          n         = n + 2'd1;
        end
        default: ;
      endcase
    end

    // mark the final result of this byte
    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    push_o.cnt  = fire ? n : 2'd0;
    push_o.res0 = res[0];
    push_o.res1 = res[1];
  end

endmodule

/* src/mbsr_out_fifo.sv */
// result queue: takes up to two results a cycle, hands out one while out_ready_i is high
// depends on mbsr_pkg
module mbsr_out_fifo import mbsr_pkg::*; #(
  parameter int unsigned Depth = OUT_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  result_t          mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q, wr_nxt;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == PtrMax) ? '0 : p + 1'b1;
  endfunction

  assign room_o      = (cnt_q <= RoomMax);
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign pop         = out_valid_o & out_ready_i;
  assign wr_nxt      = inc(wr_q);
  assign cnt_d       = cnt_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) begin
        rd_q <= inc(rd_q);
      end
      if (push_i.cnt == 2'd1) begin
        wr_q <= wr_nxt;
      end else if (push_i.cnt == 2'd2) begin
        wr_q <= inc(wr_nxt);
      end
    end
  end

endmodule

/* src/mbsr_checker.sv */
// port-level checks for the midi byte stream receiver, bound to the top level
// depends on mbsr_pkg
module mbsr_checker import mbsr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // only defined kinds leave the block, with the pad bit clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:0] <= K_SYSEX_END && !m_axis_tdata[63])
    else $error("undefined kind or pad bit set");

  // system kinds carry no channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] >= K_SONG_POS |-> m_axis_tdata[8:5] == 4'd0)
    else $error("channel on system message");

  // quarter frame values fit their fields: type in three bits, value in four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] == K_QFRAME |->
      m_axis_tdata[15:12] == 4'd0 && m_axis_tdata[22:20] == 3'd0)
    else $error("quarter frame value out of range");

endmodule

bind midi_byte_stream_receiver mbsr_checker u_mbsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
